/* design/tbg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tbg_pkg;

  // item actions
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  // shared divider widths
  localparam int DVD_W = 56;
  localparam int DVS_W = 36;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* design/tbg_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module tbg_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tbg_pkg::div_req_t req,
  output tbg_pkg::div_rsp_t     rsp
);

  localparam int CW = $clog2(tbg_pkg::DVD_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(tbg_pkg::DVD_W - 1);

  logic                        busy;
  logic                        done;
  logic [CW-1:0]               cnt;
  logic [tbg_pkg::DVD_W-1:0]   quo;
  logic [tbg_pkg::DVS_W-1:0]   rem;
  logic [tbg_pkg::DVS_W-1:0]   dvs;
  logic [tbg_pkg::DVS_W:0]     trial;
  logic [tbg_pkg::DVS_W:0]     trial_sub;
  logic                        ge;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    trial     = {rem, quo[tbg_pkg::DVD_W-1]};
    trial_sub = trial - {1'b0, dvs};
    ge        = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? trial_sub[tbg_pkg::DVS_W-1:0] : trial[tbg_pkg::DVS_W-1:0];
        quo <= {quo[tbg_pkg::DVD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

/* design/tangent_bitangent_generator.sv */
// Per-vertex tangent and bitangent generator for load, triangle and read
// items; in_ready is low while an item is at work. The time an item takes
// is set by one shared restoring divider that yields one quotient bit per
// cycle (six quotients per triangle, three per normalized vector), by a
// one-bit-per-cycle normalizing shift, a 32-step square root and a single
// shared multiplier. Vertex data sits in stores with one write and one read
// port and registered reads; a result waits in an output register while the
// next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module tangent_bitangent_generator #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [9:0]         vertex_index,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] pos_z,
  input  wire logic signed [15:0] tex_u,
  input  wire logic signed [15:0] tex_v,
  input  wire logic [9:0]         corner_a,
  input  wire logic [9:0]         corner_b,
  input  wire logic [9:0]         corner_c,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      tangent_x,
  output logic signed [15:0]      tangent_y,
  output logic signed [15:0]      tangent_z,
  output logic signed [15:0]      bitangent_x,
  output logic signed [15:0]      bitangent_y,
  output logic signed [15:0]      bitangent_z,
  output logic [1:0]              status
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
  localparam logic [2:0] DET_STEP = 3'd6;
  localparam logic [2:0] LAST_COMP = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE, S_TRI_A, S_TRI_B, S_TRI_C, S_TRI_D, S_M1, S_M2, S_M3,
    S_DIV_START, S_DIV_WAIT, S_ACC_ADDR, S_ACC_WAIT, S_ACC_WR,
    S_RD_WAIT, S_RD_CAP, S_N_MAG, S_N_SHIFT, S_N_SQ, S_N_SQRT,
    S_N_DIV_START, S_N_DIV_WAIT, S_FINISH
  } state_t;

  function automatic logic [AW-1:0] slot_idx(input logic [9:0] s);
    logic [16:0] e;
    e = {7'd0, s};
    return e[AW-1:0];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  state_t state;

  // vertex stores
  logic [47:0] pos_mem [MAX_VERTICES];
  logic [31:0] tex_mem [MAX_VERTICES];
  logic [95:0] ts_mem  [MAX_VERTICES];
  logic [95:0] bs_mem  [MAX_VERTICES];
  logic [47:0] pos_q;
  logic [31:0] tex_q;
  logic [95:0] ts_q;
  logic [95:0] bs_q;
  logic [AW-1:0] rd_addr;

  logic          ld_we;
  logic          sum_we;
  logic [AW-1:0] sum_wa;
  logic [95:0]   ts_wd;
  logic [95:0]   bs_wd;

  // triangle working registers
  logic [AW-1:0]       cor [3];
  logic signed [15:0]  pa [3];
  logic signed [15:0]  ta_u;
  logic signed [15:0]  ta_v;
  logic signed [16:0]  p1 [3];
  logic signed [16:0]  p2 [3];
  logic signed [16:0]  du1, dv1, du2, dv2;
  logic [2:0]          j;
  logic signed [34:0]  acc;
  logic signed [34:0]  det_r;
  logic signed [34:0]  diff_r;
  logic signed [34:0]  dnext;
  logic [34:0]         det_mag;
  logic [34:0]         diff_mag;
  logic [31:0]         tb [6];
  logic [31:0]         q_sat;
  logic [1:0]          c;

  // shared multiplier
  logic signed [16:0] xo, yo, zo, wo;
  logic [1:0]         jb;
  logic [1:0]         kk;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // normalization registers
  logic               sel;
  logic signed [31:0] tv [3];
  logic signed [31:0] bv [3];
  logic signed [31:0] cur [3];
  logic [31:0]        cmag [3];
  logic [31:0]        cmax;
  logic [31:0]        mag [3];
  logic [31:0]        m_r;
  logic [1:0]         k;
  logic [63:0]        len2;
  logic [63:0]        sqn;
  logic [63:0]        sres;
  logic [63:0]        sbit;
  logic [63:0]        sq_trial;
  logic [32:0]        len_r;
  logic [1:0]         ni;
  logic [15:0]        qn;
  logic signed [15:0] nval;
  logic signed [15:0] ot [3];
  logic signed [15:0] ob [3];
  logic               zflag;
  logic [1:0]         st;

  tbg_pkg::div_req_t div_req;
  tbg_pkg::div_rsp_t div_rsp;

  logic acc_in;
  logic slot_ok;
  logic tri_ok;

  assign in_ready = (state == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign slot_ok  = {7'd0, vertex_index} < MAXV;
  assign tri_ok   = ({7'd0, corner_a} < MAXV) && ({7'd0, corner_b} < MAXV) &&
                    ({7'd0, corner_c} < MAXV);

  // store write selection
  always_comb begin
    ld_we  = acc_in && (action == tbg_pkg::ACT_LOAD) && slot_ok;
    sum_we = ld_we || (state == S_ACC_WR);
    sum_wa = (state == S_ACC_WR) ? rd_addr : slot_idx(vertex_index);
    ts_wd  = '0;
    bs_wd  = '0;
    if (state == S_ACC_WR) begin
      ts_wd = {sat_add(ts_q[95:64], tb[0]), sat_add(ts_q[63:32], tb[1]),
               sat_add(ts_q[31:0], tb[2])};
      bs_wd = {sat_add(bs_q[95:64], tb[3]), sat_add(bs_q[63:32], tb[4]),
               sat_add(bs_q[31:0], tb[5])};
    end
  end

  // stores, read data registered
  always_ff @(posedge clk) begin
    if (ld_we) begin
      pos_mem[slot_idx(vertex_index)] <= {pos_x, pos_y, pos_z};
      tex_mem[slot_idx(vertex_index)] <= {tex_u, tex_v};
    end
    if (sum_we) begin
      ts_mem[sum_wa] <= ts_wd;
      bs_mem[sum_wa] <= bs_wd;
    end
    pos_q <= pos_mem[rd_addr];
    tex_q <= tex_mem[rd_addr];
    ts_q  <= ts_mem[rd_addr];
    bs_q  <= bs_mem[rd_addr];
  end

  // multiplier operand selection
  always_comb begin
    jb = 2'(j - 3'd3);
    if (j == DET_STEP) begin
      xo = du1; yo = dv2; zo = dv1; wo = du2;
    end else if (j < 3'd3) begin
      xo = p1[j[1:0]]; yo = dv2; zo = p2[j[1:0]]; wo = dv1;
    end else begin
      xo = p2[jb]; yo = du1; zo = p1[jb]; wo = du2;
    end
    kk = (k == 2'd3) ? 2'd0 : k;
    if (state == S_N_SQ) begin
      mul_a = $signed({1'b0, mag[kk]});
      mul_b = $signed({1'b0, mag[kk]});
    end else if (state == S_M1) begin
      mul_a = 33'(xo);
      mul_b = 33'(yo);
    end else begin
      mul_a = 33'(zo);
      mul_b = 33'(wo);
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // differences, magnitudes and quotient saturation
  always_comb begin
    dnext    = acc - 35'(mul_p);
    det_mag  = det_r[34] ? 35'(-det_r) : 35'(det_r);
    diff_mag = diff_r[34] ? 35'(-diff_r) : 35'(diff_r);
    if (diff_r[34] ^ det_r[34]) begin
      q_sat = (div_rsp.quotient > 56'h8000_0000) ? 32'h8000_0000 :
              32'(-div_rsp.quotient[31:0]);
    end else begin
      q_sat = (div_rsp.quotient > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF :
              div_rsp.quotient[31:0];
    end
  end

  // current vector for normalization
  always_comb begin
    cmax = '0;
    for (int i = 0; i < 3; i++) begin
      cur[i]  = sel ? bv[i] : tv[i];
      cmag[i] = cur[i][31] ? 32'(-cur[i]) : 32'(cur[i]);
      if (cmag[i] > cmax) cmax = cmag[i];
    end
    sq_trial = sres + sbit;
    qn       = div_rsp.quotient[15:0];
    nval     = cur[ni][31] ? 16'(-qn) : 16'(qn);
  end

  // divider requests
  always_comb begin
    div_req.start    = (state == S_DIV_START) || (state == S_N_DIV_START);
    if (state == S_N_DIV_START) begin
      div_req.dividend = 56'({mag[ni], 14'd0}) + 56'(len_r[32:1]);
      div_req.divisor  = 36'(len_r);
    end else begin
      div_req.dividend = 56'({diff_mag, 20'd0});
      div_req.divisor  = 36'(det_mag);
    end
  end

  tbg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            for (int i = 0; i < 3; i++) begin
              ot[i] <= '0;
              ob[i] <= '0;
            end
            zflag <= 1'b0;
            st    <= tbg_pkg::ST_OK;
            state <= S_FINISH;
            case (action)
              tbg_pkg::ACT_LOAD: begin
                if (!slot_ok) st <= tbg_pkg::ST_RANGE;
              end
              tbg_pkg::ACT_TRI: begin
                if (!tri_ok) begin
                  st <= tbg_pkg::ST_RANGE;
                end else begin
                  cor[0]  <= slot_idx(corner_a);
                  cor[1]  <= slot_idx(corner_b);
                  cor[2]  <= slot_idx(corner_c);
                  rd_addr <= slot_idx(corner_a);
                  state   <= S_TRI_A;
                end
              end
              tbg_pkg::ACT_READ: begin
                if (!slot_ok) begin
                  st <= tbg_pkg::ST_RANGE;
                end else begin
                  rd_addr <= slot_idx(vertex_index);
                  state   <= S_RD_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_TRI_A: begin
          rd_addr <= cor[1];
          state   <= S_TRI_B;
        end
        S_TRI_B: begin
          pa[0]   <= $signed(pos_q[47:32]);
          pa[1]   <= $signed(pos_q[31:16]);
          pa[2]   <= $signed(pos_q[15:0]);
          ta_u    <= $signed(tex_q[31:16]);
          ta_v    <= $signed(tex_q[15:0]);
          rd_addr <= cor[2];
          state   <= S_TRI_C;
        end
        S_TRI_C: begin
          p1[0] <= 17'($signed(pos_q[47:32])) - 17'(pa[0]);
          p1[1] <= 17'($signed(pos_q[31:16])) - 17'(pa[1]);
          p1[2] <= 17'($signed(pos_q[15:0])) - 17'(pa[2]);
          du1   <= 17'($signed(tex_q[31:16])) - 17'(ta_u);
          dv1   <= 17'($signed(tex_q[15:0])) - 17'(ta_v);
          state <= S_TRI_D;
        end
        S_TRI_D: begin
          p2[0] <= 17'($signed(pos_q[47:32])) - 17'(pa[0]);
          p2[1] <= 17'($signed(pos_q[31:16])) - 17'(pa[1]);
          p2[2] <= 17'($signed(pos_q[15:0])) - 17'(pa[2]);
          du2   <= 17'($signed(tex_q[31:16])) - 17'(ta_u);
          dv2   <= 17'($signed(tex_q[15:0])) - 17'(ta_v);
          j     <= DET_STEP;
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          acc   <= 35'(mul_p);
          state <= S_M3;
        end
        S_M3: begin
          if (j == DET_STEP) begin
            det_r <= dnext;
            if (dnext == '0) begin
              st    <= tbg_pkg::ST_DEGEN;
              state <= S_FINISH;
            end else begin
              j     <= '0;
              state <= S_M1;
            end
          end else begin
            diff_r <= dnext;
            state  <= S_DIV_START;
          end
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            tb[j] <= q_sat;
            if (j == LAST_COMP) begin
              c     <= '0;
              state <= S_ACC_ADDR;
            end else begin
              j     <= j + 1'b1;
              state <= S_M1;
            end
          end
        end
        S_ACC_ADDR: begin
          rd_addr <= cor[c];
          state   <= S_ACC_WAIT;
        end
        S_ACC_WAIT: state <= S_ACC_WR;
        S_ACC_WR: begin
          if (c == 2'd2) begin
            state <= S_FINISH;
          end else begin
            c     <= c + 1'b1;
            state <= S_ACC_ADDR;
          end
        end
        S_RD_WAIT: state <= S_RD_CAP;
        S_RD_CAP: begin
          tv[0] <= $signed(ts_q[95:64]);
          tv[1] <= $signed(ts_q[63:32]);
          tv[2] <= $signed(ts_q[31:0]);
          bv[0] <= $signed(bs_q[95:64]);
          bv[1] <= $signed(bs_q[63:32]);
          bv[2] <= $signed(bs_q[31:0]);
          sel   <= 1'b0;
          state <= S_N_MAG;
        end
        S_N_MAG: begin
          if (cmax == '0) begin
            zflag <= 1'b1;
            if (sel) state <= S_FINISH;
            else sel <= 1'b1;
          end else begin
            for (int i = 0; i < 3; i++) mag[i] <= cmag[i];
            m_r   <= cmax;
            state <= S_N_SHIFT;
          end
        end
        S_N_SHIFT: begin
          if (m_r[31:30] == 2'b00) begin
            for (int i = 0; i < 3; i++) mag[i] <= {mag[i][30:0], 1'b0};
            m_r <= {m_r[30:0], 1'b0};
          end else begin
            k     <= '0;
            len2  <= '0;
            state <= S_N_SQ;
          end
        end
        S_N_SQ: begin
          if (k != 2'd0) len2 <= len2 + mul_p[63:0];
          k <= k + 1'b1;
          if (k == 2'd3) begin
            sqn   <= len2 + mul_p[63:0];
            sres  <= '0;
            sbit  <= 64'h4000_0000_0000_0000;
            state <= S_N_SQRT;
          end
        end
        S_N_SQRT: begin
          if (sbit == '0) begin
            len_r <= sres[32:0];
            ni    <= '0;
            state <= S_N_DIV_START;
          end else begin
            if (sqn >= sq_trial) begin
              sqn  <= sqn - sq_trial;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        S_N_DIV_START: state <= S_N_DIV_WAIT;
        S_N_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (sel) ob[ni] <= nval;
            else ot[ni] <= nval;
            if (ni == 2'd2) begin
              if (sel) begin
                state <= S_FINISH;
              end else begin
                sel   <= 1'b1;
                state <= S_N_MAG;
              end
            end else begin
              ni    <= ni + 1'b1;
              state <= S_N_DIV_START;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            tangent_x   <= ot[0];
            tangent_y   <= ot[1];
            tangent_z   <= ot[2];
            bitangent_x <= ob[0];
            bitangent_y <= ob[1];
            bitangent_z <= ob[2];
            status      <= zflag ? tbg_pkg::ST_ZERO : st;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/tbg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module tbg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] tangent_x,
  input wire logic signed [15:0] tangent_y,
  input wire logic signed [15:0] tangent_z,
  input wire logic signed [15:0] bitangent_x,
  input wire logic signed [15:0] bitangent_y,
  input wire logic signed [15:0] bitangent_z,
  input wire logic [1:0]         status
);

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(tangent_x))
    else $error("result dropped or changed while stalled");

  // busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again straight after an item");

  // skipped or rejected items carry zero vectors
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tbg_pkg::ST_DEGEN || status == tbg_pkg::ST_RANGE) |->
      tangent_x == 0 && tangent_y == 0 && tangent_z == 0 &&
      bitangent_x == 0 && bitangent_y == 0 && bitangent_z == 0)
    else $error("non-zero vector on an error status");

  // x components of unit vectors stay within Q1.14 one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tangent_x <= 16'sd16384 && tangent_x >= -16'sd16384 &&
      bitangent_x <= 16'sd16384 && bitangent_x >= -16'sd16384)
    else $error("normalized component out of range");

endmodule

bind tangent_bitangent_generator tbg_checker u_tbg_checker (.*);
`default_nettype wire
